/* hdl/jsu_pkg.sv */
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_top.
`timescale 1ns / 1ps

package jsu_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       string_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [2:0] error_code;
		logic       run_last;
		logic       string_done;
	} out_item_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_CTRL     = 3'd1,
		ERR_ESCAPE   = 3'd2,
		ERR_HEX      = 3'd3,
		ERR_CUT      = 3'd4,
		ERR_NO_LOW   = 3'd5,
		ERR_BAD_LOW  = 3'd6,
		ERR_LONE_LOW = 3'd7
	} err_t;

	localparam int MAX_RUN = 4;

	// All results caused by one input byte, as handed from front to back.
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;
		logic [2:0]              nbytes;   // number of results, 1 to 4
		logic                    data_ok;  // results carry data bytes
		err_t                    err;
		logic                    done;     // closes the string
	} run_t;

	localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
	localparam logic [7:0]  CH_QUOTE     = 8'h22;
	localparam logic [7:0]  CH_SLASH     = 8'h2F;
	localparam logic [7:0]  CH_U         = 8'h75;
	localparam logic [7:0]  CTRL_LIMIT   = 8'h20;
	localparam logic [5:0]  HIGH_SURR    = 6'b110110;  // 0xD800 to 0xDBFF
	localparam logic [5:0]  LOW_SURR     = 6'b110111;  // 0xDC00 to 0xDFFF
	localparam logic [20:0] SUPP_BASE    = 21'h10000;

	// Returns {ok, value} for one ASCII hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// UTF-8 encoding of one code point as a run of one to four bytes.
	function automatic run_t utf8_run(input logic [20:0] cp);
		run_t r;
		r = '0;
		r.data_ok = 1'b1;
		r.err = ERR_NONE;
		if (cp < 21'h80) begin
			r.nbytes = 3'd1;
			r.bytes[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.nbytes = 3'd2;
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < SUPP_BASE) begin
			r.nbytes = 3'd3;
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			r.nbytes = 3'd4;
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

/* hdl/jsu_front.sv */
// Front end: decodes one input byte per accepted request into a run of results, or none.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,      // an input request is accepted this cycle
	input  in_item_t item,
	output logic     push,
	output run_t     run
);

	typedef enum logic [2:0] {
		MODE_PLAIN   = 3'd0,
		MODE_ESC     = 3'd1,
		MODE_HEX1    = 3'd2,
		MODE_WANT_BS = 3'd3,
		MODE_WANT_U  = 3'd4,
		MODE_HEX2    = 3'd5,
		MODE_DRAIN   = 3'd6
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] unit_q, unit_d;
	logic [9:0]  high_q, high_d;

	logic [7:0]  c;
	logic        last;
	logic [4:0]  hx;
	err_t        err;
	logic        emit_cp;
	logic [20:0] cp;
	logic        emit_lit;
	logic [7:0]  lit;

	assign c    = item.data_byte;
	assign last = item.string_end;
	assign hx   = hex_digit(c);

	always_comb begin
		mode_d   = mode_q;
		cnt_d    = cnt_q;
		unit_d   = unit_q;
		high_d   = high_q;
		err      = ERR_NONE;
		emit_cp  = 1'b0;
		cp       = '0;
		emit_lit = 1'b0;
		lit      = c;
		case (mode_q)
			MODE_PLAIN: begin
				if (c < CTRL_LIMIT) begin
					err = ERR_CTRL;
				end else if (c == CH_BACKSLASH) begin
					if (last) err = ERR_CUT;
					else mode_d = MODE_ESC;
				end else begin
					emit_lit = 1'b1;
				end
			end
			MODE_ESC: begin
				mode_d = MODE_PLAIN;
				case (c)
					CH_QUOTE, CH_BACKSLASH, CH_SLASH: emit_lit = 1'b1;
					8'h62: begin emit_lit = 1'b1; lit = 8'h08; end
					8'h66: begin emit_lit = 1'b1; lit = 8'h0C; end
					8'h6E: begin emit_lit = 1'b1; lit = 8'h0A; end
					8'h72: begin emit_lit = 1'b1; lit = 8'h0D; end
					8'h74: begin emit_lit = 1'b1; lit = 8'h09; end
					CH_U: begin
						if (last) begin
							err = ERR_CUT;
						end else begin
							mode_d = MODE_HEX1;
							cnt_d  = '0;
							unit_d = '0;
						end
					end
					default: err = ERR_ESCAPE;
				endcase
			end
			MODE_HEX1, MODE_HEX2: begin
				if (last && cnt_q != 2'd3) begin
					err = ERR_CUT;
				end else if (!hx[4]) begin
					err = ERR_HEX;
				end else begin
					unit_d = {unit_q[11:0], hx[3:0]};
					if (cnt_q != 2'd3) begin
						cnt_d = cnt_q + 2'd1;
					end else begin
						cnt_d = '0;
						if (mode_q == MODE_HEX1) begin
							if (unit_d[15:10] == HIGH_SURR) begin
								if (last) begin
									err = ERR_CUT;
								end else begin
									high_d = unit_d[9:0];
									mode_d = MODE_WANT_BS;
								end
							end else if (unit_d[15:10] == LOW_SURR) begin
								err = ERR_LONE_LOW;
							end else begin
								emit_cp = 1'b1;
								cp      = {5'b0, unit_d};
								mode_d  = MODE_PLAIN;
							end
						end else begin
							if (unit_d[15:10] != LOW_SURR) begin
								err = ERR_BAD_LOW;
							end else begin
								emit_cp = 1'b1;
								cp      = SUPP_BASE + {1'b0, high_q, unit_d[9:0]};
								mode_d  = MODE_PLAIN;
							end
						end
					end
				end
			end
			MODE_WANT_BS: begin
				if (last) err = ERR_CUT;
				else if (c != CH_BACKSLASH) err = ERR_NO_LOW;
				else mode_d = MODE_WANT_U;
			end
			MODE_WANT_U: begin
				if (last) begin
					err = ERR_CUT;
				end else if (c != CH_U) begin
					err = ERR_NO_LOW;
				end else begin
					mode_d = MODE_HEX2;
					cnt_d  = '0;
					unit_d = '0;
				end
			end
			default: ;
		endcase

		if (err != ERR_NONE) mode_d = MODE_DRAIN;
		if (last) begin
			mode_d = MODE_PLAIN;
			cnt_d  = '0;
			unit_d = '0;
			high_d = '0;
		end
	end

	// Data results and an error result never come from the same byte.
	always_comb begin
		run = '0;
		run.err = ERR_NONE;
		if (emit_cp) begin
			run = utf8_run(cp);
		end else if (emit_lit) begin
			run.nbytes   = 3'd1;
			run.data_ok  = 1'b1;
			run.bytes[0] = lit;
		end else begin
			run.nbytes = 3'd1;
			run.err    = err;
		end
		run.done = last;
	end

	assign push = take && (emit_cp || emit_lit || err != ERR_NONE || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			cnt_q  <= '0;
			unit_q <= '0;
			high_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			unit_q <= unit_d;
			high_q <= high_d;
		end
	end

endmodule

/* hdl/jsu_queue.sv */
// Small FIFO of decoded runs between the front and back ends.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t wr_run,
	output logic not_full,
	input  logic pop,
	output logic not_empty,
	output run_t rd_run
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	run_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign not_full  = count_q != CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign rd_run    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

/* hdl/jsu_back.sv */
// Back end: holds one run and hands out its results one per cycle while result_ready is high.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  run_t      q_run,
	output logic      q_pop,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	run_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       last_entry;
	logic       fire;

	assign last_entry = ({1'b0, idx_q} + 3'd1) == cur_q.nbytes;
	assign fire       = cur_valid_q && result_ready;
	assign q_pop      = q_valid && (!cur_valid_q || (fire && last_entry));

	assign result_valid       = cur_valid_q;
	assign result.out_byte    = cur_q.data_ok ? cur_q.bytes[idx_q] : 8'h00;
	assign result.byte_valid  = cur_q.data_ok;
	assign result.error_code  = cur_q.err;
	assign result.run_last    = last_entry;
	assign result.string_done = last_entry && cur_q.done;

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (fire) begin
			if (last_entry) cur_valid_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

endmodule

/* hdl/json_string_unescape_top.sv */
// Top level of the JSON string unescaper: front decoder, run queue, result sequencer.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//   channel  direction  handshake                     payload
//   item     in         item_valid / item_ready       in_item_t  (data_byte, string_end)
//   result   out        result_valid / result_ready   out_item_t (out_byte ... string_done)
//
// An input byte is decoded in the cycle it is accepted; its run passes through the
// run queue into the back end, whose results leave one per cycle while result_ready
// is high. Throughput is one input byte per cycle while each byte gives at most one
// result and result_ready is high; a byte with k results (1 to 4) holds the back end.
// The input stalls only when the run queue of QUEUE_DEPTH entries is full.
// Reset returns the decoder to plain text and empties the queue and back end.
`timescale 1ns / 1ps

module json_string_unescape_top import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic take;
	logic push;
	run_t wr_run;
	logic q_valid;
	logic q_pop;
	run_t q_run;

	assign take = item_valid && item_ready;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.push   (push),
		.run    (wr_run)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_run    (wr_run),
		.not_full  (item_ready),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rd_run    (q_run)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_run        (q_run),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// A result that closes a string is always the last one of its request.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.string_done |-> result.run_last)
		else $error("string_done without run_last");

	// Error and empty results stand alone in their run.
	a_nodata_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_valid |-> result.run_last)
		else $error("non-data result not last in run");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error_code != ERR_NONE
			|-> !result.byte_valid && result.out_byte == 8'h00)
		else $error("error result carries data");

	// A run enters the back end only when the previous one is finished.
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !q_pop)
		else $error("run replaced while a result is stalled");

endmodule
